/* hdl/joms_pkg.sv */
// Package with the character codes shared by the JSON object member splitter.
package joms_pkg;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [7:0] CHAR_COLON     = 8'h3A;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;

endpackage

/* hdl/joms_req_if.sv */
// Interface carrying the byte transactions of the object text.
interface joms_req_if;

   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       final_byte;

   modport source (output valid, output text_byte, output final_byte, input ready);
   modport sink   (input valid, input text_byte, input final_byte, output ready);

endinterface

/* hdl/joms_rsp_if.sv */
// Interface carrying the member span result transactions.
interface joms_rsp_if #(
   parameter int OFFSET_BITS = 16
);

   logic                   valid;
   logic                   ready;
   logic [OFFSET_BITS-1:0] key_offset;
   logic [OFFSET_BITS-1:0] key_length;
   logic [OFFSET_BITS-1:0] value_offset;
   logic [OFFSET_BITS-1:0] value_length;
   logic                   pair_valid;
   logic                   object_done;
   logic                   length_overflow;

   modport source (
      output valid, output key_offset, output key_length, output value_offset,
      output value_length, output pair_valid, output object_done,
      output length_overflow, input ready
   );
   modport sink (
      input valid, input key_offset, input key_length, input value_offset,
      input value_length, input pair_valid, input object_done,
      input length_overflow, output ready
   );

endinterface

/* hdl/json_object_member_splitter.sv */
// Top level of the JSON object member splitter.
//
// The req_if channel takes one byte of a JSON object text per transaction,
// with final_byte set on its last byte. The first and last bytes are the
// enclosing braces and are not scanned. The rsp_if channel gives one
// transaction for every top-level comma that closes a value, carrying the
// key and value offsets and lengths, and one for the final byte, with
// object_done set and the last pair if a value was still open.
// Every byte is scanned in the cycle it is accepted, so one byte is taken
// per cycle while req_if.ready is high; each result is registered on rsp_if.
// The scan state sits in registers updated at each accepted byte, and the
// results go through an output register backed by a one-entry skid
// register. req_if.ready is low only while the skid register is full, so a
// stalled receiver holds at most two results before input is stopped.
// Synchronous reset clears the scan state and empties both result
// registers; after the final byte the scan state returns to that same
// reset state, ready for the next object.
module json_object_member_splitter
   import joms_pkg::*;
#(
   parameter int OFFSET_BITS = 16,
   parameter int DEPTH_BITS  = 16
) (
   input  logic              clock,
   input  logic              reset,
   joms_req_if.sink          req_if,
   joms_rsp_if.source        rsp_if
);

   localparam logic [OFFSET_BITS-1:0] OFS_MAX   = '1;
   localparam logic [OFFSET_BITS-1:0] OFS_ZERO  = '0;
   localparam logic [OFFSET_BITS-1:0] OFS_ONE   = OFFSET_BITS'(1);
   localparam logic [DEPTH_BITS-1:0]  DEPTH_ONE = DEPTH_BITS'(1);

   typedef struct packed {
      logic [OFFSET_BITS-1:0] key_offset;
      logic [OFFSET_BITS-1:0] key_length;
      logic [OFFSET_BITS-1:0] value_offset;
      logic [OFFSET_BITS-1:0] value_length;
      logic                   pair_valid;
      logic                   object_done;
      logic                   length_overflow;
   } result_type;

   logic [OFFSET_BITS-1:0] byte_position_ff, byte_position_in;
   logic                   first_seen_ff, first_seen_in;
   logic                   quote_open_ff, quote_open_in;
   logic                   escape_pending_ff, escape_pending_in;
   logic                   value_open_ff, value_open_in;
   logic [DEPTH_BITS-1:0]  brace_depth_ff, brace_depth_in;
   logic [DEPTH_BITS-1:0]  bracket_depth_ff, bracket_depth_in;
   logic [OFFSET_BITS-1:0] span_start_ff, span_start_in;
   logic [OFFSET_BITS-1:0] held_key_offset_ff, held_key_offset_in;
   logic [OFFSET_BITS-1:0] held_key_length_ff, held_key_length_in;
   logic                   overflow_seen_ff, overflow_seen_in;

   logic                   out_valid_ff, out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   result_type             out_data_ff, out_data_in;
   result_type             skid_data_ff, skid_data_in;

   logic                   req_accept;
   logic                   rsp_take;
   logic                   produce;
   result_type             result;

   logic [OFFSET_BITS-1:0] cur_position;
   logic                   position_at_max;
   logic                   overflow_now;
   logic                   at_top;
   logic [OFFSET_BITS-1:0] span_plus_one;
   logic [OFFSET_BITS-1:0] cur_plus_one;
   logic                   emit_pair;
   logic                   emit_done;
   logic [OFFSET_BITS-1:0] span_end;

   assign req_accept = req_if.valid && req_if.ready;
   assign rsp_take   = rsp_if.valid && rsp_if.ready;

   assign position_at_max = (byte_position_ff == OFS_MAX);
   assign cur_position    = !first_seen_ff ? OFS_ZERO :
                            (position_at_max ? OFS_MAX : byte_position_ff + OFS_ONE);
   assign overflow_now    = overflow_seen_ff || (first_seen_ff && position_at_max);
   assign at_top          = (brace_depth_ff == '0) && (bracket_depth_ff == '0);
   assign span_plus_one   = (span_start_ff == OFS_MAX) ? OFS_MAX : span_start_ff + OFS_ONE;
   assign cur_plus_one    = (cur_position == OFS_MAX) ? OFS_MAX : cur_position + OFS_ONE;

   // Scan state update for the byte now offered.
   always_comb begin
      byte_position_in   = cur_position;
      first_seen_in      = 1'b1;
      quote_open_in      = quote_open_ff;
      escape_pending_in  = 1'b0;
      value_open_in      = value_open_ff;
      brace_depth_in     = brace_depth_ff;
      bracket_depth_in   = bracket_depth_ff;
      span_start_in      = span_start_ff;
      held_key_offset_in = held_key_offset_ff;
      held_key_length_in = held_key_length_ff;
      overflow_seen_in   = overflow_now;
      emit_pair          = 1'b0;
      emit_done          = 1'b0;

      priority if (req_if.final_byte) begin
         emit_pair          = value_open_ff;
         emit_done          = 1'b1;
         byte_position_in   = OFS_ZERO;
         first_seen_in      = 1'b0;
         quote_open_in      = 1'b0;
         value_open_in      = 1'b0;
         brace_depth_in     = '0;
         bracket_depth_in   = '0;
         span_start_in      = OFS_ONE;
         held_key_offset_in = OFS_ZERO;
         held_key_length_in = OFS_ZERO;
         overflow_seen_in   = 1'b0;
      end else if (!first_seen_ff) begin
         escape_pending_in = escape_pending_ff;
      end else begin
         unique case (req_if.text_byte)
            CHAR_BACKSLASH: begin
               escape_pending_in = !escape_pending_ff;
            end
            CHAR_QUOTE: begin
               if (!escape_pending_ff && !value_open_ff && at_top) begin
                  if (!quote_open_ff) begin
                     span_start_in = cur_position;
                  end else begin
                     held_key_offset_in = span_plus_one;
                     held_key_length_in = (cur_position > span_plus_one) ?
                                          cur_position - span_plus_one : OFS_ZERO;
                  end
               end
               if (!escape_pending_ff) begin
                  quote_open_in = !quote_open_ff;
               end
            end
            CHAR_LBRACE: begin
               if (!quote_open_ff) begin
                  brace_depth_in = brace_depth_ff + DEPTH_ONE;
               end
            end
            CHAR_RBRACE: begin
               if (!quote_open_ff) begin
                  brace_depth_in = brace_depth_ff - DEPTH_ONE;
               end
            end
            CHAR_LBRACKET: begin
               if (!quote_open_ff) begin
                  bracket_depth_in = bracket_depth_ff + DEPTH_ONE;
               end
            end
            CHAR_RBRACKET: begin
               if (!quote_open_ff) begin
                  bracket_depth_in = bracket_depth_ff - DEPTH_ONE;
               end
            end
            CHAR_COLON: begin
               if (!quote_open_ff && at_top) begin
                  value_open_in = 1'b1;
                  span_start_in = cur_plus_one;
               end
            end
            CHAR_COMMA: begin
               if (value_open_ff && !quote_open_ff && at_top) begin
                  emit_pair     = 1'b1;
                  value_open_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign span_end = (cur_position > span_start_ff) ? cur_position - span_start_ff : OFS_ZERO;
   assign produce  = req_accept && (emit_pair || emit_done);

   always_comb begin
      result.key_offset      = emit_pair ? held_key_offset_ff : OFS_ZERO;
      result.key_length      = emit_pair ? held_key_length_ff : OFS_ZERO;
      result.value_offset    = emit_pair ? span_start_ff : OFS_ZERO;
      result.value_length    = emit_pair ? span_end : OFS_ZERO;
      result.pair_valid      = emit_pair;
      result.object_done     = emit_done;
      result.length_overflow = overflow_now;
   end

   // Output register with a one-entry skid register behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      priority if (rsp_take && skid_valid_ff) begin
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end else if (rsp_take || !out_valid_ff) begin
         out_valid_in = produce;
         out_data_in  = result;
      end else if (produce) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff   <= OFS_ZERO;
         first_seen_ff      <= 1'b0;
         quote_open_ff      <= 1'b0;
         escape_pending_ff  <= 1'b0;
         value_open_ff      <= 1'b0;
         brace_depth_ff     <= '0;
         bracket_depth_ff   <= '0;
         span_start_ff      <= OFS_ONE;
         held_key_offset_ff <= OFS_ZERO;
         held_key_length_ff <= OFS_ZERO;
         overflow_seen_ff   <= 1'b0;
         out_valid_ff       <= 1'b0;
         skid_valid_ff      <= 1'b0;
      end else begin
         if (req_accept) begin
            byte_position_ff   <= byte_position_in;
            first_seen_ff      <= first_seen_in;
            quote_open_ff      <= quote_open_in;
            escape_pending_ff  <= escape_pending_in;
            value_open_ff      <= value_open_in;
            brace_depth_ff     <= brace_depth_in;
            bracket_depth_ff   <= bracket_depth_in;
            span_start_ff      <= span_start_in;
            held_key_offset_ff <= held_key_offset_in;
            held_key_length_ff <= held_key_length_in;
            overflow_seen_ff   <= overflow_seen_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_if.ready           = !skid_valid_ff;
   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.key_offset      = out_data_ff.key_offset;
   assign rsp_if.key_length      = out_data_ff.key_length;
   assign rsp_if.value_offset    = out_data_ff.value_offset;
   assign rsp_if.value_length    = out_data_ff.value_length;
   assign rsp_if.pair_valid      = out_data_ff.pair_valid;
   assign rsp_if.object_done     = out_data_ff.object_done;
   assign rsp_if.length_overflow = out_data_ff.length_overflow;

`ifndef SYNTHESIS
   // The skid register is only filled behind a full output register.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("Skid register holds a result while the output register is empty.");

   // The final byte of an object leaves the scan state as after reset.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_if.final_byte) |=>
         (!first_seen_ff && !value_open_ff && !quote_open_ff && !overflow_seen_ff))
      else $error("Scan state not cleared after the final byte.");

   // Once overflow is flagged, the byte position stays saturated.
   assert property (@(posedge clock) disable iff (reset)
      overflow_seen_ff |-> (byte_position_ff == OFS_MAX))
      else $error("Overflow flagged while the byte position is not saturated.");

   // Before the opening byte nothing of the object has been recorded.
   assert property (@(posedge clock) disable iff (reset)
      !first_seen_ff |-> ((byte_position_ff == OFS_ZERO) && !value_open_ff))
      else $error("Scan state recorded before the first byte.");

   // A transaction that yields a result is always stored.
   assert property (@(posedge clock) disable iff (reset)
      produce |=> out_valid_ff)
      else $error("Result lost after an accepted transaction.");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench that streams JSON object texts through the member splitter.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import joms_pkg::*;

   localparam int OFS_W = 16;
   localparam int DEP_W = 16;
   localparam logic [OFS_W-1:0] OFS_MAX = '1;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_BYTES = 1150;
   localparam int HOLD_CYCLES = 120;
   localparam logic [7:0] SPECIALS [8] = '{CHAR_BACKSLASH, CHAR_QUOTE, CHAR_LBRACE,
      CHAR_RBRACE, CHAR_LBRACKET, CHAR_RBRACKET, CHAR_COLON, CHAR_COMMA};

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } text_item_t;

   typedef struct packed {
      logic [OFS_W-1:0] key_offset;
      logic [OFS_W-1:0] key_length;
      logic [OFS_W-1:0] value_offset;
      logic [OFS_W-1:0] value_length;
      logic             pair_valid;
      logic             object_done;
      logic             length_overflow;
   } member_span_t;

   logic clock;
   logic reset;

   joms_req_if req_if ();
   joms_rsp_if #(.OFFSET_BITS(OFS_W)) rsp_if ();

   json_object_member_splitter #(
      .OFFSET_BITS(OFS_W),
      .DEPTH_BITS (DEP_W)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   text_item_t   byte_queue[$];
   member_span_t expected_spans[$];
   int stim_count     = 0;
   int bytes_accepted = 0;
   int mismatch_count = 0;
   int stall_cycles   = 0;
   int hold_left      = 0;
   int holds_done     = 0;
   bit req_fire       = 1'b0;
   bit rsp_fire       = 1'b0;

   logic [OFS_W-1:0] scan_position;
   logic [OFS_W-1:0] scan_span_start;
   logic [OFS_W-1:0] scan_key_offset;
   logic [OFS_W-1:0] scan_key_length;
   logic [DEP_W-1:0] scan_braces;
   logic [DEP_W-1:0] scan_brackets;
   logic             scan_started;
   logic             scan_in_string;
   logic             scan_escaped;
   logic             scan_in_value;
   logic             scan_overflow;

   function automatic logic [OFS_W-1:0] sat_next(logic [OFS_W-1:0] v);
      return (v == OFS_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [OFS_W-1:0] span_len(logic [OFS_W-1:0] stop,
                                                 logic [OFS_W-1:0] start);
      return (stop > start) ? stop - start : '0;
   endfunction

   function automatic void clear_scan();
      scan_position   = '0;
      scan_span_start = OFS_W'(1);
      scan_key_offset = '0;
      scan_key_length = '0;
      scan_braces     = '0;
      scan_brackets   = '0;
      scan_started    = 1'b0;
      scan_in_string  = 1'b0;
      scan_escaped    = 1'b0;
      scan_in_value   = 1'b0;
      scan_overflow   = 1'b0;
   endfunction

   function automatic member_span_t make_span(logic pair, logic done, logic [OFS_W-1:0] stop);
      member_span_t s;
      s = '0;
      if (pair) begin
         s.key_offset   = scan_key_offset;
         s.key_length   = scan_key_length;
         s.value_offset = scan_span_start;
         s.value_length = span_len(stop, scan_span_start);
         s.pair_valid   = 1'b1;
      end
      s.object_done     = done;
      s.length_overflow = scan_overflow;
      return s;
   endfunction

   function automatic void predict_byte(logic [7:0] c, logic fin);
      logic [OFS_W-1:0] cur;
      logic             was_escaped;
      logic             at_top;
      if (!scan_started) begin
         cur = '0;
      end else if (scan_position == OFS_MAX) begin
         cur           = OFS_MAX;
         scan_overflow = 1'b1;
      end else begin
         cur = scan_position + 1'b1;
      end
      scan_position = cur;
      if (fin) begin
         expected_spans.push_back(make_span(scan_in_value, 1'b1, cur));
         clear_scan();
      end else if (!scan_started) begin
         scan_started = 1'b1;
      end else begin
         was_escaped = scan_escaped;
         at_top      = (scan_braces == 0) && (scan_brackets == 0);
         case (c)
            CHAR_BACKSLASH: scan_escaped = !scan_escaped;
            CHAR_QUOTE: begin
               if (!scan_escaped && !scan_in_value && at_top) begin
                  if (!scan_in_string) begin
                     scan_span_start = cur;
                  end else begin
                     scan_key_offset = sat_next(scan_span_start);
                     scan_key_length = span_len(cur, sat_next(scan_span_start));
                  end
               end
               if (!scan_escaped) scan_in_string = !scan_in_string;
            end
            CHAR_LBRACE:   if (!scan_in_string) scan_braces = scan_braces + 1'b1;
            CHAR_RBRACE:   if (!scan_in_string) scan_braces = scan_braces - 1'b1;
            CHAR_LBRACKET: if (!scan_in_string) scan_brackets = scan_brackets + 1'b1;
            CHAR_RBRACKET: if (!scan_in_string) scan_brackets = scan_brackets - 1'b1;
            CHAR_COLON: begin
               if (!scan_in_string && at_top) begin
                  scan_in_value   = 1'b1;
                  scan_span_start = sat_next(cur);
               end
            end
            CHAR_COMMA: begin
               if (scan_in_value && !scan_in_string && at_top) begin
                  expected_spans.push_back(make_span(1'b1, 1'b0, cur));
                  scan_in_value = 1'b0;
               end
            end
            default: ;
         endcase
         if (was_escaped) scan_escaped = 1'b0;
      end
   endfunction

   function automatic void check_field(string name, logic [OFS_W-1:0] want,
                                       logic [OFS_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic bit take_break();
      return !(bytes_accepted >= 900 && bytes_accepted < 1300) && ($urandom_range(0, 99) < 9);
   endfunction

   function automatic void put_byte(logic [7:0] b, logic fin = 1'b0);
      text_item_t item;
      item.text_byte  = b;
      item.final_byte = fin;
      byte_queue.push_back(item);
      stim_count++;
   endfunction

   function automatic void put_chars(string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endfunction

   function automatic void put_string();
      int n;
      n = $urandom_range(0, 4);
      put_byte(CHAR_QUOTE);
      repeat (n) begin
         case ($urandom_range(0, 9))
            0: begin
               put_byte(CHAR_BACKSLASH);
               put_byte($urandom_range(0, 1) ? SPECIALS[$urandom_range(0, 7)] : 8'h6E);
            end
            1: put_byte(SPECIALS[$urandom_range(2, 7)]);
            default: put_byte(8'(8'h61 + $urandom_range(0, 25)));
         endcase
      end
      put_byte(CHAR_QUOTE);
   endfunction

   function automatic void put_member(int depth);
      put_string();
      if ($urandom_range(0, 7) == 0) put_byte(8'h20);
      put_byte(CHAR_COLON);
      put_value(depth);
   endfunction

   function automatic void put_value(int depth);
      int n;
      n = $urandom_range(0, 3);
      case ($urandom_range(0, (depth < 3) ? 5 : 2))
         0: repeat (n + 1) put_byte(8'(8'h30 + $urandom_range(0, 9)));
         1: put_chars($urandom_range(0, 1) ? "true" : " null ");
         2: put_string();
         3: begin
            put_byte(CHAR_LBRACKET);
            for (int i = 0; i < n; i++) begin
               if (i != 0) put_byte(CHAR_COMMA);
               put_value(depth + 1);
            end
            put_byte(CHAR_RBRACKET);
         end
         4: begin
            put_byte(CHAR_LBRACE);
            for (int i = 0; i < n; i++) begin
               if (i != 0) put_byte(CHAR_COMMA);
               put_member(depth + 1);
            end
            put_byte(CHAR_RBRACE);
         end
         default: put_chars("-1.5e3");
      endcase
   endfunction

   function automatic void put_random_object();
      int n;
      if ($urandom_range(0, 4) == 0) begin
         n = $urandom_range(0, 11);
         repeat (n) begin
            put_byte($urandom_range(0, 1) ? SPECIALS[$urandom_range(0, 7)]
                                          : 8'($urandom_range(0, 255)));
         end
         put_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         put_byte(($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : CHAR_LBRACE);
         n = $urandom_range(0, 4);
         for (int i = 0; i < n; i++) begin
            if (i != 0) put_byte(CHAR_COMMA);
            put_member(0);
         end
         put_byte(CHAR_RBRACE, 1'b1);
      end
   endfunction

   task automatic wait_for_drain();
      do @(posedge clock);
      while (byte_queue.size() != 0 || req_if.valid || expected_spans.size() != 0);
   endtask

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.text_byte  = '0;
      req_if.final_byte = 1'b0;
      rsp_if.ready      = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
   end

   always @(negedge clock) begin
      text_item_t item;
      if (reset) begin
         req_if.valid      <= 1'b0;
         req_if.text_byte  <= '0;
         req_if.final_byte <= 1'b0;
      end else if (!req_if.valid || req_fire) begin
         if (byte_queue.size() != 0 && !take_break()) begin
            item = byte_queue.pop_front();
            req_if.valid      <= 1'b1;
            req_if.text_byte  <= item.text_byte;
            req_if.final_byte <= item.final_byte;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (hold_left == 0 && holds_done < 2 && bytes_accepted >= 300 + 400 * holds_done) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !take_break();
         end
      end
   end

   always @(posedge clock) begin
      member_span_t want;
      req_fire = !reset && req_if.valid && req_if.ready;
      rsp_fire = !reset && rsp_if.valid && rsp_if.ready;
      if (reset) clear_scan();
      if (req_fire) begin
         predict_byte(req_if.text_byte, req_if.final_byte);
         bytes_accepted++;
      end
      if (rsp_fire) begin
         if (expected_spans.size() == 0) begin
            $display("%0t ns: expected no transaction, got key_offset %0d value_offset %0d done %0b",
                     $time, rsp_if.key_offset, rsp_if.value_offset, rsp_if.object_done);
            mismatch_count++;
         end else begin
            want = expected_spans.pop_front();
            check_field("key_offset", want.key_offset, rsp_if.key_offset);
            check_field("key_length", want.key_length, rsp_if.key_length);
            check_field("value_offset", want.value_offset, rsp_if.value_offset);
            check_field("value_length", want.value_length, rsp_if.value_length);
            check_field("pair_valid", OFS_W'(want.pair_valid), OFS_W'(rsp_if.pair_valid));
            check_field("object_done", OFS_W'(want.object_done), OFS_W'(rsp_if.object_done));
            check_field("length_overflow", OFS_W'(want.length_overflow),
                        OFS_W'(rsp_if.length_overflow));
         end
      end
      stall_cycles = (reset || req_fire || rsp_fire) ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int random_goal;
      put_byte(8'h00, 1'b1);
      put_chars("{\"a\":1,:2");
      put_byte(CHAR_RBRACE, 1'b1);
      put_byte(CHAR_LBRACE);
      put_byte(CHAR_BACKSLASH);
      put_byte(CHAR_QUOTE);
      put_byte(CHAR_COLON);
      put_byte(8'hFF);
      put_byte(CHAR_RBRACE);
      put_byte(CHAR_COMMA);
      put_byte(CHAR_RBRACE, 1'b1);
      put_chars("{\"\\\"\":[,]");
      put_byte(CHAR_RBRACE, 1'b1);
      wait_for_drain();
      random_goal = stim_count + RANDOM_BYTES / 2;
      while (stim_count < random_goal) put_random_object();
      wait_for_drain();
      random_goal = random_goal + RANDOM_BYTES / 2;
      while (stim_count < random_goal) put_random_object();
      wait_for_drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

/* filelist.f */
hdl/joms_pkg.sv
hdl/joms_req_if.sv
hdl/joms_rsp_if.sv
hdl/json_object_member_splitter.sv
tb/tb.sv
